### hw/rtl/lfu_pkg.sv
// ----------------------------------------------------------------------------
// LFU frame package
// Shared widths, result kind codes, the compare-unit status struct and the
// saturating vote increment.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int SLOTS_DEF     = 16;
  localparam int ID_WIDTH_DEF  = 8;
  localparam int MAX_RESULTS   = 16;

  localparam int IN_DATA_W     = 8;
  localparam int IN_USER_W     = 1;
  localparam int OUT_ID_W      = 8;
  localparam int VOTES_W       = 16;
  localparam int TIME_W        = 32;
  localparam int OUT_DATA_W    = OUT_ID_W + VOTES_W;
  localparam int KIND_W        = 3;
  localparam int CFG_W         = 5;

  localparam logic [VOTES_W-1:0] VOTES_MAX = {VOTES_W{1'b1}};
  localparam logic [VOTES_W-1:0] VOTES_ONE = VOTES_W'(1);
  localparam logic [TIME_W-1:0]  TIME_MAX  = {TIME_W{1'b1}};

  localparam logic [KIND_W-1:0] KIND_VOTE    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REPLACE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_LIST    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_EMPTY   = 3'd4;

  localparam logic FUNC_RECOMMEND = 1'b0;
  localparam logic FUNC_LIST      = 1'b1;

  // Status of the shared compare unit for the entry currently being scanned.
  typedef struct packed {
    logic hit;         // entry member equals the key
    logic vic_better;  // entry is a better eviction victim than the best so far
    logic lst_ok;      // entry member lies above the last listed member
    logic lst_less;    // entry member is below the best pick so far
  } lfu_cmp_t;

  function automatic logic [VOTES_W-1:0] votes_bump(input logic [VOTES_W-1:0] v);
    votes_bump = (v == VOTES_MAX) ? v : v + VOTES_ONE;
  endfunction

endpackage

### hw/rtl/lfu_slot_ram.sv
// ----------------------------------------------------------------------------
// LFU slot memory
// One write port and one read port with registered read data; holds the
// member id, vote count and insertion time of every slot.
// ----------------------------------------------------------------------------
module lfu_slot_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 56,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/lfu_cmp.sv
// ----------------------------------------------------------------------------
// LFU compare unit
// Compares one scanned slot entry against the key, the running best entry
// and the last listed member; shared by the recommend and list scans.
// ----------------------------------------------------------------------------
module lfu_cmp #(
  parameter int ID_WIDTH = 8
) (
  input  logic [ID_WIDTH-1:0]        key,
  input  logic [ID_WIDTH-1:0]        prev,
  input  logic                       have_prev,
  input  logic [ID_WIDTH-1:0]        ent_mem,
  input  logic [lfu_pkg::VOTES_W-1:0] ent_votes,
  input  logic [lfu_pkg::TIME_W-1:0]  ent_time,
  input  logic [ID_WIDTH-1:0]        best_mem,
  input  logic [lfu_pkg::VOTES_W-1:0] best_votes,
  input  logic [lfu_pkg::TIME_W-1:0]  best_time,
  output lfu_pkg::lfu_cmp_t          res
);

  import lfu_pkg::*;

  logic mem_lt;

  assign mem_lt = ent_mem < best_mem;

  always_comb begin
    res.hit        = (ent_mem == key);
    // Fewest votes first, then oldest insertion, then smaller id.
    res.vic_better = (ent_votes < best_votes) ||
                     ((ent_votes == best_votes) &&
                      ((ent_time < best_time) ||
                       ((ent_time == best_time) && mem_lt)));
    res.lst_ok     = !have_prev || (ent_mem > prev);
    res.lst_less   = mem_lt;
  end

endmodule

### hw/rtl/lfu_frame_replacement.sv
// ----------------------------------------------------------------------------
// LFU frame replacement
// Frame of candidate slots with vote counts and insertion times; recommend
// beats vote, insert or evict, list beats walk the members in id order.
// ----------------------------------------------------------------------------
// Recommend: n slot memory reads, one per cycle, n = active frame size,
//   through the shared compare unit, then the result beat.
// List: (k + 1) scan passes of n reads each for k members, one result beat
//   per member or one empty beat; out_tready low with a full output
//   register holds a beat back. The input is ready again once an item's
//   last beat is loaded. Reset clears all slot valid bits and the
//   insertion counter, sets the frame size to LIM; config is always ready.
// ----------------------------------------------------------------------------
module lfu_frame_replacement #(
  parameter int SLOTS    = lfu_pkg::SLOTS_DEF,
  parameter int ID_WIDTH = lfu_pkg::ID_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [lfu_pkg::IN_DATA_W-1:0]  in_tdata,   // [7:0] candidate_id
  input  logic [lfu_pkg::IN_USER_W-1:0]  in_tuser,   // [0] func
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [lfu_pkg::OUT_DATA_W-1:0] out_tdata,  // [7:0] member_id, [23:8] votes
  output logic [lfu_pkg::KIND_W-1:0]     out_tuser,  // [2:0] kind
  output logic                           out_tlast,  // last
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lfu_pkg::CFG_W-1:0]      cfg_data    // [4:0] frame_size
);

  import lfu_pkg::*;

  localparam int LIM = (SLOTS < MAX_RESULTS) ? SLOTS : MAX_RESULTS;
  localparam int CW  = $clog2(LIM + 1);
  localparam int IW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int EW  = TIME_W + VOTES_W + ID_WIDTH;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_RFIN = 2'd2;
  localparam logic [1:0] S_LFIN = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic                func_r, func_nxt;
  logic [ID_WIDTH-1:0] key_r, key_nxt;
  logic [CW-1:0]       n_eff_r;
  logic [TIME_W-1:0]   seq_r, seq_nxt;
  logic [SLOTS-1:0]    valid_r, valid_nxt;

  logic [CW-1:0]       addr_r, addr_nxt;
  logic                dv_r, dv_nxt;
  logic [IW-1:0]       didx_r, didx_nxt;

  logic                hit_f_r, hit_f_nxt;
  logic [IW-1:0]       hit_idx_r, hit_idx_nxt;
  logic [VOTES_W-1:0]  hit_votes_r, hit_votes_nxt;
  logic [TIME_W-1:0]   hit_time_r, hit_time_nxt;
  logic                free_f_r, free_f_nxt;
  logic [IW-1:0]       free_idx_r, free_idx_nxt;

  logic                best_f_r, best_f_nxt;
  logic [IW-1:0]       best_idx_r, best_idx_nxt;
  logic [ID_WIDTH-1:0] best_mem_r, best_mem_nxt;
  logic [VOTES_W-1:0]  best_votes_r, best_votes_nxt;
  logic [TIME_W-1:0]   best_time_r, best_time_nxt;

  logic                have_prev_r, have_prev_nxt;
  logic [ID_WIDTH-1:0] prev_r, prev_nxt;
  logic                pend_f_r, pend_f_nxt;
  logic [ID_WIDTH-1:0] pend_mem_r, pend_mem_nxt;
  logic [VOTES_W-1:0]  pend_votes_r, pend_votes_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]   out_kind_r;
  logic [OUT_ID_W-1:0] out_mem_r;
  logic [VOTES_W-1:0]  out_votes_r;
  logic                out_last_r;

  logic                emit;
  logic [KIND_W-1:0]   emit_kind;
  logic [OUT_ID_W-1:0] emit_mem;
  logic [VOTES_W-1:0]  emit_votes;
  logic                emit_last;

  logic                rd_en;
  logic [IW-1:0]       rd_addr;
  logic [EW-1:0]       rd_data;
  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  logic [EW-1:0]       wr_data;

  logic [ID_WIDTH-1:0] ent_mem;
  logic [VOTES_W-1:0]  ent_votes;
  logic [TIME_W-1:0]   ent_time;
  logic                ent_valid;
  logic                can_emit;
  logic [VOTES_W-1:0]  hit_bumped;
  lfu_cmp_t            cmp;

  assign ent_mem    = rd_data[ID_WIDTH-1:0];
  assign ent_votes  = rd_data[ID_WIDTH +: VOTES_W];
  assign ent_time   = rd_data[ID_WIDTH + VOTES_W +: TIME_W];
  assign ent_valid  = valid_r[didx_r];
  assign can_emit   = !out_valid_r || out_tready;
  assign hit_bumped = votes_bump(hit_votes_r);

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_votes_r, out_mem_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  lfu_slot_ram #(
    .DEPTH (SLOTS),
    .WIDTH (EW),
    .AW    (IW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lfu_cmp #(
    .ID_WIDTH (ID_WIDTH)
  ) u_cmp (
    .key        (key_r),
    .prev       (prev_r),
    .have_prev  (have_prev_r),
    .ent_mem    (ent_mem),
    .ent_votes  (ent_votes),
    .ent_time   (ent_time),
    .best_mem   (best_mem_r),
    .best_votes (best_votes_r),
    .best_time  (best_time_r),
    .res        (cmp)
  );

  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    key_nxt        = key_r;
    seq_nxt        = seq_r;
    valid_nxt      = valid_r;
    addr_nxt       = addr_r;
    dv_nxt         = dv_r;
    didx_nxt       = didx_r;
    hit_f_nxt      = hit_f_r;
    hit_idx_nxt    = hit_idx_r;
    hit_votes_nxt  = hit_votes_r;
    hit_time_nxt   = hit_time_r;
    free_f_nxt     = free_f_r;
    free_idx_nxt   = free_idx_r;
    best_f_nxt     = best_f_r;
    best_idx_nxt   = best_idx_r;
    best_mem_nxt   = best_mem_r;
    best_votes_nxt = best_votes_r;
    best_time_nxt  = best_time_r;
    have_prev_nxt  = have_prev_r;
    prev_nxt       = prev_r;
    pend_f_nxt     = pend_f_r;
    pend_mem_nxt   = pend_mem_r;
    pend_votes_nxt = pend_votes_r;

    rd_en      = 1'b0;
    rd_addr    = IW'(addr_r);
    wr_en      = 1'b0;
    wr_addr    = best_idx_r;
    wr_data    = {seq_r, VOTES_ONE, key_r};
    emit       = 1'b0;
    emit_kind  = KIND_EMPTY;
    emit_mem   = '0;
    emit_votes = '0;
    emit_last  = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          func_nxt      = in_tuser[0];
          key_nxt       = ID_WIDTH'(in_tdata);
          addr_nxt      = '0;
          dv_nxt        = 1'b0;
          hit_f_nxt     = 1'b0;
          free_f_nxt    = 1'b0;
          best_f_nxt    = 1'b0;
          have_prev_nxt = 1'b0;
          pend_f_nxt    = 1'b0;
          state_nxt     = S_SCAN;
        end
      end

      S_SCAN: begin
        dv_nxt = 1'b0;
        if (addr_r < n_eff_r) begin
          rd_en    = 1'b1;
          dv_nxt   = 1'b1;
          didx_nxt = IW'(addr_r);
          addr_nxt = CW'(addr_r + 1'b1);
        end
        if (dv_r) begin
          if (func_r == FUNC_RECOMMEND) begin
            if (ent_valid && cmp.hit && !hit_f_r) begin
              hit_f_nxt     = 1'b1;
              hit_idx_nxt   = didx_r;
              hit_votes_nxt = ent_votes;
              hit_time_nxt  = ent_time;
            end
            if (!ent_valid && !free_f_r) begin
              free_f_nxt   = 1'b1;
              free_idx_nxt = didx_r;
            end
            if (ent_valid && (!best_f_r || cmp.vic_better)) begin
              best_f_nxt     = 1'b1;
              best_idx_nxt   = didx_r;
              best_mem_nxt   = ent_mem;
              best_votes_nxt = ent_votes;
              best_time_nxt  = ent_time;
            end
          end else if (ent_valid && cmp.lst_ok && (!best_f_r || cmp.lst_less)) begin
            best_f_nxt     = 1'b1;
            best_idx_nxt   = didx_r;
            best_mem_nxt   = ent_mem;
            best_votes_nxt = ent_votes;
            best_time_nxt  = ent_time;
          end
        end else if (!(addr_r < n_eff_r)) begin
          state_nxt = (func_r == FUNC_LIST) ? S_LFIN : S_RFIN;
        end
      end

      S_RFIN: begin
        if (can_emit) begin
          emit      = 1'b1;
          wr_en     = 1'b1;
          seq_nxt   = (seq_r == TIME_MAX) ? seq_r : seq_r + 1'b1;
          state_nxt = S_IDLE;
          if (hit_f_r) begin
            // A vote on a present member keeps its insertion time.
            wr_addr    = hit_idx_r;
            wr_data    = {hit_time_r, hit_bumped, key_r};
            emit_kind  = KIND_VOTE;
            emit_mem   = OUT_ID_W'(key_r);
            emit_votes = hit_bumped;
          end else if (free_f_r) begin
            wr_addr              = free_idx_r;
            valid_nxt[free_idx_r] = 1'b1;
            emit_kind            = KIND_INSERT;
            emit_mem             = OUT_ID_W'(key_r);
            emit_votes           = VOTES_ONE;
          end else begin
            wr_addr    = best_idx_r;
            emit_kind  = KIND_REPLACE;
            emit_mem   = OUT_ID_W'(best_mem_r);
            emit_votes = best_votes_r;
          end
        end
      end

      S_LFIN: begin
        // A pick is held back one pass so that the final beat can carry last.
        if (best_f_r) begin
          if (!pend_f_r || can_emit) begin
            if (pend_f_r) begin
              emit       = 1'b1;
              emit_kind  = KIND_LIST;
              emit_mem   = OUT_ID_W'(pend_mem_r);
              emit_votes = pend_votes_r;
              emit_last  = 1'b0;
            end
            pend_f_nxt     = 1'b1;
            pend_mem_nxt   = best_mem_r;
            pend_votes_nxt = best_votes_r;
            have_prev_nxt  = 1'b1;
            prev_nxt       = best_mem_r;
            best_f_nxt     = 1'b0;
            addr_nxt       = '0;
            state_nxt      = S_SCAN;
          end
        end else if (can_emit) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
          if (pend_f_r) begin
            emit_kind  = KIND_LIST;
            emit_mem   = OUT_ID_W'(pend_mem_r);
            emit_votes = pend_votes_r;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = emit ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seq_r       <= '0;
      valid_r     <= '0;
      n_eff_r     <= CW'(LIM);
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seq_r       <= seq_nxt;
      valid_r     <= valid_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        if (cfg_data > CFG_W'(LIM)) begin
          n_eff_r <= CW'(LIM);
        end else if (cfg_data == '0) begin
          n_eff_r <= CW'(1);
        end else begin
          n_eff_r <= CW'(cfg_data);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    key_r        <= key_nxt;
    addr_r       <= addr_nxt;
    didx_r       <= didx_nxt;
    hit_f_r      <= hit_f_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_votes_r  <= hit_votes_nxt;
    hit_time_r   <= hit_time_nxt;
    free_f_r     <= free_f_nxt;
    free_idx_r   <= free_idx_nxt;
    best_f_r     <= best_f_nxt;
    best_idx_r   <= best_idx_nxt;
    best_mem_r   <= best_mem_nxt;
    best_votes_r <= best_votes_nxt;
    best_time_r  <= best_time_nxt;
    have_prev_r  <= have_prev_nxt;
    prev_r       <= prev_nxt;
    pend_f_r     <= pend_f_nxt;
    pend_mem_r   <= pend_mem_nxt;
    pend_votes_r <= pend_votes_nxt;
    if (emit) begin
      out_kind_r  <= emit_kind;
      out_mem_r   <= emit_mem;
      out_votes_r <= emit_votes;
      out_last_r  <= emit_last;
    end
  end

endmodule
